>>> src/rpd_pkg.sv
// Shared constants, types and helpers for the packet deframer.
// Used by every module of the block; depends on nothing.
package rpd_pkg;

    localparam logic [7:0]  START_MARK    = 8'h24;   // '$'
    localparam logic [7:0]  END_MARK      = 8'h23;   // '#'
    localparam logic [7:0]  ACK_GOOD      = 8'h2B;   // '+'
    localparam logic [7:0]  ACK_BAD       = 8'h2D;   // '-'
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_LOW  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       packet_restart;
        logic       packet_good;
        logic       packet_bad;
        logic       overrun;
        logic       ack_valid;
        logic [7:0] ack_byte;
    } t_result;

    // ASCII hex digit to value; anything else reads as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

>>> src/rpd_parser.sv
// Framing state machine: phase, running checksum, high digit and payload count.
// Builds one result per byte combinationally. Depends on rpd_pkg.
module rpd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [7:0]        i_byte,
    input  logic [15:0]       i_max_len,
    output rpd_pkg::t_result  o_result
);

    rpd_pkg::t_phase  r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [3:0]       r_high, n_high;
    logic [15:0]      r_count, n_count;
    logic [16:0]      w_count_inc;
    logic [7:0]       w_sent;
    rpd_pkg::t_result w_res;

    assign w_count_inc = {1'b0, r_count} + 17'd1;
    assign w_sent      = {r_high, rpd_pkg::hex_value(i_byte)};

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_high  = r_high;
        n_count = r_count;
        w_res   = '0;
        unique case (r_phase)
            rpd_pkg::PH_WAIT: begin
                if (i_byte == rpd_pkg::START_MARK) begin
                    n_sum              = 8'd0;
                    n_high             = 4'd0;
                    n_count            = 16'd0;
                    n_phase            = rpd_pkg::PH_BODY;
                    w_res.packet_restart = 1'b1;
                end
            end
            rpd_pkg::PH_BODY: begin
                if (i_byte == rpd_pkg::START_MARK) begin
                    n_sum              = 8'd0;
                    n_high             = 4'd0;
                    n_count            = 16'd0;
                    w_res.packet_restart = 1'b1;
                end else if (i_byte == rpd_pkg::END_MARK) begin
                    n_phase = rpd_pkg::PH_HIGH;
                end else begin
                    w_res.payload_valid = 1'b1;
                    w_res.payload_byte  = i_byte;
                    n_sum               = r_sum + i_byte;
                    // limit reached: pass the byte, flag overrun, drop the packet
                    if (w_count_inc >= {1'b0, i_max_len}) begin
                        w_res.overrun = 1'b1;
                        n_sum         = 8'd0;
                        n_high        = 4'd0;
                        n_count       = 16'd0;
                        n_phase       = rpd_pkg::PH_WAIT;
                    end else begin
                        n_count = w_count_inc[15:0];
                    end
                end
            end
            rpd_pkg::PH_HIGH: begin
                n_high  = rpd_pkg::hex_value(i_byte);
                n_phase = rpd_pkg::PH_LOW;
            end
            rpd_pkg::PH_LOW: begin
                w_res.ack_valid = 1'b1;
                if (w_sent == r_sum) begin
                    w_res.packet_good = 1'b1;
                    w_res.ack_byte    = rpd_pkg::ACK_GOOD;
                end else begin
                    w_res.packet_bad = 1'b1;
                    w_res.ack_byte   = rpd_pkg::ACK_BAD;
                end
                n_sum   = 8'd0;
                n_high  = 4'd0;
                n_count = 16'd0;
                n_phase = rpd_pkg::PH_WAIT;
            end
            default: begin
                n_phase = rpd_pkg::PH_WAIT;
            end
        endcase
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rpd_pkg::PH_WAIT;
            r_sum   <= 8'd0;
            r_high  <= 4'd0;
            r_count <= 16'd0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

endmodule

>>> src/rpd_out_reg.sv
// Result register of the deframer: holds one result until the sink takes it.
// Depends on rpd_pkg.
module rpd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rpd_pkg::t_result i_result,
    input  logic             i_tready,
    output logic             o_tvalid,
    output logic             o_free,
    output rpd_pkg::t_result o_result
);

    logic             r_valid;
    rpd_pkg::t_result r_result;

    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> src/rsp_packet_deframer_core.sv
// Packet deframer top level: input register, framing parser, result register.
// Input byte and result are registered; 1 byte per cycle unless output stalls.
// Sync active-low reset clears the pipeline, returns to waiting for '$' and
// sets max_payload_len to 4096. Depends on rpd_pkg, rpd_parser, rpd_out_reg.
module rsp_packet_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] payload_byte, [8] packet_restart, [9] packet_good, [10] packet_bad,
    // [11] overrun, [19:12] ack_byte, [23:20] zero
    output logic [rpd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] payload_valid, [1] ack_valid
    output logic [rpd_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data    // max_payload_len
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [15:0]      r_max_len;
    logic             w_out_free;
    logic             w_adv;
    rpd_pkg::t_result w_res;
    rpd_pkg::t_result w_out;

    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max_len  <= rpd_pkg::MAX_LEN_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    rpd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_result  (w_res)
    );

    rpd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_result (w_res),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_free   (w_out_free),
        .o_result (w_out)
    );

    assign o_m_axis_tdata = {4'd0, w_out.ack_byte, w_out.overrun, w_out.packet_bad,
                             w_out.packet_good, w_out.packet_restart, w_out.payload_byte};
    assign o_m_axis_tuser = {w_out.ack_valid, w_out.payload_valid};

endmodule

>>> src/rpd_checker.sv
// Port-level checks for the packet deframer, bound to the top level.
// Depends on rsp_packet_deframer_core ports and rpd_pkg.
module rpd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [rpd_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [rpd_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

    // an acknowledge carries exactly one verdict and the matching character
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            $onehot(o_m_axis_tdata[10:9]) &&
            ((o_m_axis_tdata[9] && o_m_axis_tdata[19:12] == rpd_pkg::ACK_GOOD) ||
             (o_m_axis_tdata[10] && o_m_axis_tdata[19:12] == rpd_pkg::ACK_BAD)))
        else $error("acknowledge inconsistent with verdict");

    // no verdict and no ack character without an acknowledge
    a_no_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |->
            o_m_axis_tdata[10:9] == 2'b00 && o_m_axis_tdata[19:12] == 8'h00)
        else $error("verdict without acknowledge");

    // overrun only comes with a payload byte; idle byte field stays zero; a payload byte has no restart or ack
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (!o_m_axis_tdata[11] || o_m_axis_tuser[0]) &&
            (o_m_axis_tuser[0] || o_m_axis_tdata[7:0] == 8'h00) &&
            !(o_m_axis_tuser[0] && (o_m_axis_tdata[8] || o_m_axis_tuser[1])))
        else $error("payload flags inconsistent");

endmodule

bind rsp_packet_deframer_core rpd_checker u_rpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> bench/tb_rsp_packet_deframer_core.sv
// Testbench for rsp_packet_deframer_core: streams received bytes, predicts each
// result from a software model of the framing, and compares every result.
// Depends on rpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_rsp_packet_deframer_core;

    // Tracks the framing state and holds the results the block owes us.
    class frame_tracker;
        rpd_pkg::t_phase  phase;
        logic [7:0]       run_sum;
        logic [3:0]       sent_hi;
        logic [15:0]      body_count;
        logic [15:0]      limit;
        rpd_pkg::t_result owed[$];
        int               mismatch_count;

        function new();
            phase          = rpd_pkg::PH_WAIT;
            run_sum        = 8'd0;
            sent_hi        = 4'd0;
            body_count     = 16'd0;
            limit          = rpd_pkg::MAX_LEN_RESET;
            mismatch_count = 0;
        endfunction

        function automatic logic [3:0] digit_value(input logic [7:0] c);
            if (c >= "0" && c <= "9") return 4'(c - 8'h30);
            if (c >= "a" && c <= "f") return 4'(c - 8'h61 + 8'd10);
            if (c >= "A" && c <= "F") return 4'(c - 8'h41 + 8'd10);
            return 4'd0;
        endfunction

        function void drop_packet();
            run_sum    = 8'd0;
            sent_hi    = 4'd0;
            body_count = 16'd0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Advance the model by one accepted byte and queue its result.
        function void take_byte(input logic [7:0] b);
            rpd_pkg::t_result r;
            logic [7:0]       sent;
            r = '0;
            case (phase)
                rpd_pkg::PH_WAIT: begin
                    if (b == rpd_pkg::START_MARK) begin
                        drop_packet();
                        phase = rpd_pkg::PH_BODY;
                        r.packet_restart = 1'b1;
                    end
                end
                rpd_pkg::PH_BODY: begin
                    if (b == rpd_pkg::START_MARK) begin
                        drop_packet();
                        r.packet_restart = 1'b1;
                    end else if (b == rpd_pkg::END_MARK) begin
                        phase = rpd_pkg::PH_HIGH;
                    end else begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = b;
                        run_sum         = run_sum + b;
                        // a limit of zero acts like one; a lowered limit trips at once
                        if (int'(body_count) + 1 >= int'(limit)) begin
                            r.overrun = 1'b1;
                            drop_packet();
                            phase = rpd_pkg::PH_WAIT;
                        end else begin
                            body_count = body_count + 16'd1;
                        end
                    end
                end
                rpd_pkg::PH_HIGH: begin
                    sent_hi = digit_value(b);
                    phase   = rpd_pkg::PH_LOW;
                end
                default: begin
                    sent        = {sent_hi, digit_value(b)};
                    r.ack_valid = 1'b1;
                    if (sent == run_sum) begin
                        r.packet_good = 1'b1;
                        r.ack_byte    = rpd_pkg::ACK_GOOD;
                    end else begin
                        r.packet_bad = 1'b1;
                        r.ack_byte   = rpd_pkg::ACK_BAD;
                    end
                    drop_packet();
                    phase = rpd_pkg::PH_WAIT;
                end
            endcase
            owed.push_back(r);
        endfunction

        function void cmp_field(input string name, input int unsigned want,
                                input int unsigned got);
            if (want != got) begin
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(input logic [rpd_pkg::OUT_TDATA_W-1:0] tdata,
                                   input logic [rpd_pkg::OUT_TUSER_W-1:0] tuser);
            rpd_pkg::t_result want;
            if (owed.size() == 0) begin
                $display("%0t mismatch unexpected result: expected none actual %0h/%0h",
                         $time, tdata, tuser);
                mismatch_count++;
                return;
            end
            want = owed.pop_front();
            cmp_field("payload_valid",  want.payload_valid,  tuser[0]);
            cmp_field("payload_byte",   want.payload_byte,   tdata[7:0]);
            cmp_field("packet_restart", want.packet_restart, tdata[8]);
            cmp_field("packet_good",    want.packet_good,    tdata[9]);
            cmp_field("packet_bad",     want.packet_bad,     tdata[10]);
            cmp_field("overrun",        want.overrun,        tdata[11]);
            cmp_field("ack_valid",      want.ack_valid,      tuser[1]);
            cmp_field("ack_byte",       want.ack_byte,       tdata[19:12]);
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = 16'd0;

    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [rpd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [rpd_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser;
    logic                            o_cfg_ready;

    frame_tracker sb = new();
    bit           idle_on  = 1'b1;
    int           hold_req = 0;

    rsp_packet_deframer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // Result side: check every accepted result, stall at random or on request.
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_m_axis_tvalid && m_tready) begin
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
            end
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 37);
            end
        end
    end

    task automatic offer_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_byte(b);
    endtask

    // Hold the sender until every owed result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.limit = v;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(255));
        while (v == rpd_pkg::START_MARK || v == rpd_pkg::END_MARK);
        return v;
    endfunction

    // Mostly well-formed packets with random bodies; some noise, restarts,
    // missing end markers and corrupted checksums.
    task automatic random_traffic(input int n_items);
        int          sent;
        int          len;
        int          pick;
        logic [7:0]  sum;
        logic [7:0]  b;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                offer_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
                sum = 8'd0;
                offer_byte(rpd_pkg::START_MARK);
                sent++;
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(49) == 0) begin
                        b   = rpd_pkg::START_MARK;
                        sum = 8'd0;
                    end else begin
                        b   = body_byte();
                        sum = sum + b;
                    end
                    offer_byte(b);
                    sent++;
                end
                if ($urandom_range(99) < 85) begin
                    offer_byte(rpd_pkg::END_MARK);
                    pick = $urandom_range(99);
                    if (pick < 75) begin
                        offer_byte(hex_char(sum[7:4]));
                        offer_byte(hex_char(sum[3:0]));
                    end else if (pick < 90) begin
                        sum = sum + 8'($urandom_range(1, 255));
                        offer_byte(hex_char(sum[7:4]));
                        offer_byte(hex_char(sum[3:0]));
                    end else begin
                        offer_byte(8'($urandom_range(255)));
                        offer_byte(8'($urandom_range(255)));
                    end
                    sent += 3;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] limits[6];
        limits = '{16'd4096, 16'd1, 16'd7, 16'd65535, 16'd12, 16'd1};
        limits[5] = 16'($urandom_range(1, 64));

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // noise while waiting, then a good packet with body extremes
        offer_byte(8'h00);
        offer_byte(8'hFF);
        offer_byte(rpd_pkg::START_MARK);
        offer_byte(8'h00);
        offer_byte(8'hFF);
        offer_byte(8'h41);
        offer_byte(rpd_pkg::END_MARK);
        offer_byte("4");
        offer_byte("0");
        // restart inside the body, then a bad checksum in upper case
        offer_byte(rpd_pkg::START_MARK);
        offer_byte("A");
        offer_byte(rpd_pkg::START_MARK);
        offer_byte("b");
        offer_byte(rpd_pkg::END_MARK);
        offer_byte("F");
        offer_byte("F");
        // markers and non-hex bytes read as digit zero
        offer_byte(rpd_pkg::START_MARK);
        offer_byte(rpd_pkg::END_MARK);
        offer_byte(rpd_pkg::START_MARK);
        offer_byte("g");
        drain_results();

        // zero limit acts like one
        write_limit(16'd0);
        offer_byte(rpd_pkg::START_MARK);
        offer_byte("y");
        drain_results();

        // lower the limit under the running count mid-packet
        write_limit(16'd10);
        offer_byte(rpd_pkg::START_MARK);
        offer_byte(8'h01);
        offer_byte(8'h02);
        offer_byte(8'h03);
        drain_results();
        write_limit(16'd2);
        offer_byte(8'h04);
        drain_results();

        foreach (limits[p]) begin
            write_limit(limits[p]);
            idle_on = (p != 2);
            if (p == 3) begin
                hold_req = 150;
            end
            random_traffic(82);
            if (p == 1) begin
                drain_results();
            end
            random_traffic(82);
            drain_results();
        end
        idle_on = 1'b1;

        repeat (10) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
